>>> hdl/rsmp_pkg.sv
// Shared types and constants of the linear interpolation resampler.
`default_nettype none

package rsmp_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int STEP_REG_W   = 21;
  localparam int FRAC_MAX     = 24;
  localparam int MAX_CHANNELS = 2;
  localparam int JOB_DEPTH    = 4;
  localparam int RES_DEPTH    = 4;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 32;

  typedef enum logic {
    REG_STEP   = 1'b0,
    REG_STEREO = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [STEP_REG_W-1:0] resample_step;
    logic                  stereo_mode;
  } cfg_t;

  // One interpolation job: the two frame ends and the fraction between them.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] a_left;
    logic signed [SAMPLE_W-1:0] a_right;
    logic signed [SAMPLE_W-1:0] b_left;
    logic signed [SAMPLE_W-1:0] b_right;
    logic [FRAC_MAX-1:0]        frac;
    logic                       last_of_run;
    logic                       stream_done;
  } job_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
    logic                       last_of_run;
    logic                       stream_done;
  } res_t;

endpackage

`default_nettype wire

>>> hdl/linear_interp_resampler_unit.sv
// The position sequencer steps the position once per result, issuing one job per cycle while
// the job queue has room; a frame gives at most 16 results, or none. A new frame may wait in
// the input register while the sequencer is still busy with the last one.
// Reset (synchronous, rst high) clears history, position and queues; the step returns to 1.0
// and stereo mode to on. No clearing pass is needed.
`default_nettype none

module linear_interp_resampler_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rsmp_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [rsmp_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [rsmp_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready,
  input  logic                               push,
  output logic                               full,
  input  logic signed [15:0]                 sample_left,
  input  logic signed [15:0]                 sample_right,
  input  logic                               start_of_stream,
  input  logic                               end_of_stream,
  output logic                               empty,
  input  logic                               pop,
  output logic signed [15:0]                 out_left,
  output logic signed [15:0]                 out_right,
  output logic                               last_of_run,
  output logic                               stream_done
);

  import rsmp_pkg::*;

  cfg_t     cfg;
  reg_idx_t reg_idx;
  logic     cfg_write;

  job_t     jq_wdata;
  job_t     jq_rdata;
  logic     jq_push;
  logic     jq_pop;
  logic     jq_full;
  logic     jq_empty;
  res_t     res_data;

  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.resample_step <= STEP_REG_W'(64'd1 << FRAC_BITS);
      cfg.stereo_mode   <= 1'b1;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_STEP:   cfg.resample_step <= pwdata[STEP_REG_W-1:0];
        REG_STEREO: cfg.stereo_mode   <= pwdata[0];
        default:    cfg.stereo_mode   <= cfg.stereo_mode;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_STEP:   prdata = CFG_DATA_W'(cfg.resample_step);
      REG_STEREO: prdata = CFG_DATA_W'(cfg.stereo_mode);
      default:    prdata = '0;
    endcase
  end

  rsmp_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .push            (push),
    .full            (full),
    .sample_left     (sample_left),
    .sample_right    (sample_right),
    .start_of_stream (start_of_stream),
    .end_of_stream   (end_of_stream),
    .jq_full         (jq_full),
    .jq_push         (jq_push),
    .jq_data         (jq_wdata)
  );

  rsmp_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (JOB_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .push  (jq_push),
    .wdata (jq_wdata),
    .pop   (jq_pop),
    .rdata (jq_rdata),
    .full  (jq_full),
    .empty (jq_empty),
    .count ()
  );

  rsmp_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .jq_empty (jq_empty),
    .jq_data  (jq_rdata),
    .jq_pop   (jq_pop),
    .pop      (pop),
    .empty    (empty),
    .res_data (res_data)
  );

  assign out_left    = res_data.out_left;
  assign out_right   = res_data.out_right;
  assign last_of_run = res_data.last_of_run;
  assign stream_done = res_data.stream_done;

endmodule

`default_nettype wire

>>> hdl/rsmp_fifo.sv
// Small register-based first-in first-out queue.
`default_nettype none

module rsmp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        mem[wr_ptr] <= wdata;
        wr_ptr      <= wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/rsmp_front.sv
// Front end: takes source frames, tracks position and history, issues interpolation jobs.
`default_nettype none

module rsmp_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  rsmp_pkg::cfg_t      cfg,
  input  logic                push,
  output logic                full,
  input  logic signed [15:0]  sample_left,
  input  logic signed [15:0]  sample_right,
  input  logic                start_of_stream,
  input  logic                end_of_stream,
  input  logic                jq_full,
  output logic                jq_push,
  output rsmp_pkg::job_t      jq_data
);

  import rsmp_pkg::*;

  localparam int POS_W = FRAC_BITS + 5;
  localparam int SW    = (POS_W > STEP_REG_W) ? POS_W : STEP_REG_W;
  localparam logic [POS_W-1:0] POS_ONE  = POS_W'(1) << FRAC_BITS;
  localparam logic [SW-1:0]    STEP_MIN = SW'(1) << (FRAC_BITS - 3);
  localparam logic [SW-1:0]    STEP_MAX = SW'(1) << (FRAC_BITS + 4);

  typedef enum logic [1:0] {IDLE, INTERP, HOLD} state_t;

  state_t                     state;
  logic                       in_valid;
  logic signed [SAMPLE_W-1:0] in_left;
  logic signed [SAMPLE_W-1:0] in_right;
  logic                       in_sos;
  logic                       in_eos;

  logic signed [SAMPLE_W-1:0] prev_left;
  logic signed [SAMPLE_W-1:0] prev_right;
  logic [POS_W-1:0]           pos;
  logic                       have_prev;

  logic [POS_W-1:0]           wp;
  logic signed [SAMPLE_W-1:0] w_al;
  logic signed [SAMPLE_W-1:0] w_ar;
  logic signed [SAMPLE_W-1:0] w_bl;
  logic signed [SAMPLE_W-1:0] w_br;
  logic                       w_eos;

  logic                       stereo;
  logic [SW-1:0]              step_raw;
  logic [POS_W-1:0]           step;
  logic                       start;
  logic signed [SAMPLE_W-1:0] cur_right;
  logic                       hp;
  logic [POS_W-1:0]           p0;
  logic [POS_W-1:0]           pm1;
  logic [POS_W-1:0]           pn;
  logic [POS_W-1:0]           q;
  logic                       pass;
  logic                       hold_more;
  logic                       job_last;

  always_comb begin
    stereo   = cfg.stereo_mode && (MAX_CHANNELS > 1);
    step_raw = SW'(cfg.resample_step);
    if (step_raw < STEP_MIN) begin
      step = POS_W'(STEP_MIN);
    end else if (step_raw > STEP_MAX) begin
      step = POS_W'(STEP_MAX);
    end else begin
      step = POS_W'(step_raw);
    end
  end

  // A start of stream discards the history before the frame is classified.
  assign start     = in_valid && (state == IDLE);
  assign full      = in_valid && !start;
  assign cur_right = stereo ? in_right : '0;
  assign hp        = have_prev && !in_sos;
  assign p0        = in_sos ? '0 : pos;
  assign pm1       = p0 - POS_ONE;

  assign pn        = wp + step;
  assign q         = pn - POS_ONE;
  assign pass      = (pn >= POS_ONE);
  assign hold_more = w_eos && (q < POS_ONE);
  assign job_last  = pass && !((state == INTERP) && hold_more);

  assign jq_push = (state != IDLE) && !jq_full;

  always_comb begin
    jq_data.a_left      = (state == HOLD) ? w_bl : w_al;
    jq_data.a_right     = (state == HOLD) ? w_br : w_ar;
    jq_data.b_left      = w_bl;
    jq_data.b_right     = w_br;
    jq_data.frac        = FRAC_MAX'(wp[FRAC_BITS-1:0]);
    jq_data.last_of_run = job_last;
    jq_data.stream_done = job_last && w_eos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      in_valid   <= 1'b0;
      prev_left  <= '0;
      prev_right <= '0;
      pos        <= '0;
      have_prev  <= 1'b0;
    end else begin
      if (push && !full) begin
        in_valid <= 1'b1;
        in_left  <= sample_left;
        in_right <= sample_right;
        in_sos   <= start_of_stream;
        in_eos   <= end_of_stream;
      end else if (start) begin
        in_valid <= 1'b0;
      end

      case (state)
        IDLE: begin
          if (in_valid) begin
            w_al  <= prev_left;
            w_ar  <= stereo ? prev_right : '0;
            w_bl  <= in_left;
            w_br  <= cur_right;
            w_eos <= in_eos;
            if (hp && (p0 < POS_ONE)) begin
              state <= INTERP;
              wp    <= p0;
            end else if (in_eos && (!hp || (pm1 < POS_ONE))) begin
              state <= HOLD;
              wp    <= hp ? pm1 : p0;
            end else if (in_eos) begin
              prev_left  <= '0;
              prev_right <= '0;
              pos        <= '0;
              have_prev  <= 1'b0;
            end else begin
              prev_left  <= in_left;
              prev_right <= cur_right;
              pos        <= hp ? pm1 : p0;
              have_prev  <= 1'b1;
            end
          end
        end
        INTERP: begin
          if (!jq_full) begin
            if (!pass) begin
              wp <= pn;
            end else if (hold_more) begin
              state <= HOLD;
              wp    <= q;
            end else begin
              state <= IDLE;
              if (w_eos) begin
                prev_left  <= '0;
                prev_right <= '0;
                pos        <= '0;
                have_prev  <= 1'b0;
              end else begin
                prev_left  <= w_bl;
                prev_right <= w_br;
                pos        <= q;
                have_prev  <= 1'b1;
              end
            end
          end
        end
        HOLD: begin
          if (!jq_full) begin
            if (!pass) begin
              wp <= pn;
            end else begin
              state      <= IDLE;
              prev_left  <= '0;
              prev_right <= '0;
              pos        <= '0;
              have_prev  <= 1'b0;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  a_no_history_zero_pos: assert property (@(posedge clk) disable iff (rst)
    !have_prev |-> (pos == '0))
    else $error("position is non-zero without history");

  a_work_pos_below_one: assert property (@(posedge clk) disable iff (rst)
    (state != IDLE) |-> (wp < POS_ONE))
    else $error("working position reached one frame while busy");

  a_hold_only_at_end: assert property (@(posedge clk) disable iff (rst)
    (state == HOLD) |-> w_eos)
    else $error("holding a frame that does not end the stream");

  a_done_clears_history: assert property (@(posedge clk) disable iff (rst)
    (jq_push && jq_data.stream_done) |=> (!have_prev && (pos == '0)))
    else $error("history survived the end of the stream");

endmodule

`default_nettype wire

>>> hdl/rsmp_back.sv
// Back end: interpolation datapath with rounding, saturation and the result queue.
`default_nettype none

module rsmp_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           jq_empty,
  input  rsmp_pkg::job_t jq_data,
  output logic           jq_pop,
  input  logic           pop,
  output logic           empty,
  output rsmp_pkg::res_t res_data
);

  import rsmp_pkg::*;

  localparam int PW = FRAC_BITS + 18;
  localparam int VW = FRAC_BITS + 19;
  localparam int RW = VW - FRAC_BITS;
  localparam int CW = $clog2(RES_DEPTH + 1);
  localparam logic signed [VW-1:0] HALF = VW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [RW-1:0] SMAX = RW'(32767);
  localparam logic signed [RW-1:0] SMIN = ~SMAX;

  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [RW-1:0] x);
    logic signed [SAMPLE_W-1:0] y;
    if (x > SMAX) begin
      y = SMAX[SAMPLE_W-1:0];
    end else if (x < SMIN) begin
      y = SMIN[SAMPLE_W-1:0];
    end else begin
      y = x[SAMPLE_W-1:0];
    end
    return y;
  endfunction

  logic                       take;
  logic signed [16:0]         diff_l;
  logic signed [16:0]         diff_r;
  logic signed [FRAC_BITS:0]  frac_s;

  logic                       s1_valid;
  logic signed [SAMPLE_W-1:0] s1_al;
  logic signed [SAMPLE_W-1:0] s1_ar;
  logic signed [PW-1:0]       s1_pl;
  logic signed [PW-1:0]       s1_pr;
  logic                       s1_last;
  logic                       s1_done;

  logic signed [VW-1:0]       v_l;
  logic signed [VW-1:0]       v_r;
  logic signed [VW-1:0]       r_l;
  logic signed [VW-1:0]       r_r;

  res_t                       res_wdata;
  logic                       res_full;
  logic [CW-1:0]              res_count;

  // A job leaves the queue only when the result queue has a free slot for it.
  assign take   = !jq_empty && (({1'b0, res_count} + (CW+1)'(s1_valid)) < (CW+1)'(RES_DEPTH));
  assign jq_pop = take;

  assign diff_l = 17'(jq_data.b_left) - 17'(jq_data.a_left);
  assign diff_r = 17'(jq_data.b_right) - 17'(jq_data.a_right);
  assign frac_s = {1'b0, jq_data.frac[FRAC_BITS-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take;
      if (take) begin
        s1_al   <= jq_data.a_left;
        s1_ar   <= jq_data.a_right;
        s1_pl   <= PW'(diff_l) * PW'(frac_s);
        s1_pr   <= PW'(diff_r) * PW'(frac_s);
        s1_last <= jq_data.last_of_run;
        s1_done <= jq_data.stream_done;
      end
    end
  end

  // Adding half a step before the arithmetic shift rounds ties upwards.
  assign v_l = (VW'(s1_al) <<< FRAC_BITS) + VW'(s1_pl) + HALF;
  assign v_r = (VW'(s1_ar) <<< FRAC_BITS) + VW'(s1_pr) + HALF;
  assign r_l = v_l >>> FRAC_BITS;
  assign r_r = v_r >>> FRAC_BITS;

  always_comb begin
    res_wdata.out_left    = sat16(r_l[RW-1:0]);
    res_wdata.out_right   = sat16(r_r[RW-1:0]);
    res_wdata.last_of_run = s1_last;
    res_wdata.stream_done = s1_done;
  end

  rsmp_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (s1_valid),
    .wdata (res_wdata),
    .pop   (pop),
    .rdata (res_data),
    .full  (res_full),
    .empty (empty),
    .count (res_count)
  );

  a_no_result_overflow: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> !res_full)
    else $error("result written into a full queue");

  a_take_has_room: assert property (@(posedge clk) disable iff (rst)
    take |-> (res_count < CW'(RES_DEPTH)))
    else $error("job taken without room for its result");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_done) |-> s1_last)
    else $error("end of stream result is not the last of its run");

endmodule

`default_nettype wire
